### rtl/core/length_prefixed_varint_encoder_macros.svh
// assertion helpers for the checker file
`ifndef LENGTH_PREFIXED_VARINT_ENCODER_MACROS_SVH
`define LENGTH_PREFIXED_VARINT_ENCODER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define LPVE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lpve_pkg.sv
package lpve_pkg;

  // width of the value port and default number of used value bits
  localparam int unsigned ValueW      = 32;
  localparam int unsigned ValueBitsDef = 32;

  // code byte layout
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenBits = 3;
  localparam int unsigned LowBits = ByteW - LenBits;

  // item handed from the length stages to the serializer
  typedef struct packed {
    logic               valid;
    logic               final_value;
    logic [LenBits-1:0] len_m1;
  } ctl_t;

endpackage

### rtl/core/lpve_front.sv
module lpve_front #(
  parameter int unsigned VW = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [lpve_pkg::ValueW-1:0] value_i,
  input  logic                   final_value_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output lpve_pkg::ctl_t         ctl_o,
  output logic [VW-1:0]          value_o,
  input  logic                   ser_ready_i
);
  import lpve_pkg::*;

  localparam int unsigned SbW  = $clog2(VW + 1);
  localparam int unsigned SumW = $clog2(VW + 11);

  logic          v1_q, v2_q;
  logic [VW-1:0] val1_q, val2_q;
  logic          fin1_q, fin2_q;
  logic [LenBits-1:0] len2_q;

  logic load1, load2, take2;
  logic [SbW-1:0]  sb;
  logic [SumW-1:0] sum, nbytes;
  logic [LenBits-1:0] len_m1_d;

  assign take2      = v2_q && ser_ready_i;
  assign load2      = v1_q && (!v2_q || take2);
  assign load1      = in_valid_i && (!v1_q || load2);
  assign in_stall_o = v1_q && !load2;

  // significant bit count: position of the highest set bit plus one
  always_comb begin
    sb = '0;
    for (int i = 0; i < VW; i++) begin
      if (val1_q[i]) sb = SbW'(i + 1);
    end
  end

  // fewest bytes n with 8n-3 >= bit count, zero gives one byte
  assign sum      = SumW'(sb) + SumW'(10);
  assign nbytes   = sum >> 3;
  assign len_m1_d = LenBits'(nbytes - SumW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (load1) v1_q <= 1'b1;
      else if (load2) v1_q <= 1'b0;
      if (load2) v2_q <= 1'b1;
      else if (take2) v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      val1_q <= value_i[VW-1:0];
      fin1_q <= final_value_i;
    end
    if (load2) begin
      val2_q <= val1_q;
      fin2_q <= fin1_q;
      len2_q <= len_m1_d;
    end
  end

  assign ctl_o.valid       = v2_q;
  assign ctl_o.final_value = fin2_q;
  assign ctl_o.len_m1      = len2_q;
  assign value_o           = val2_q;

endmodule

### rtl/core/lpve_ser.sv
module lpve_ser #(
  parameter int unsigned VW = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpve_pkg::ctl_t             ctl_i,
  input  logic [VW-1:0]              value_i,
  output logic                       ser_ready_o,
  output logic [lpve_pkg::ByteW-1:0] code_byte_o,
  output logic                       last_of_value_o,
  output logic                       end_of_block_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i
);
  import lpve_pkg::*;

  localparam int unsigned MaxBytes = (VW + 10) / 8;
  localparam int unsigned PosW     = $clog2(MaxBytes);
  localparam int unsigned PadW     = MaxBytes * ByteW;

  logic               busy_q;
  logic [VW-1:0]      val_q;
  logic               fin_q, first_q;
  logic [PosW-1:0]    pos_q;
  logic [LenBits-1:0] len_q;

  logic               oval_q, olast_q, oeob_q;
  logic [ByteW-1:0]   obyte_q;

  logic               out_free, emit, done, load;
  logic [PadW-1:0]    padded;
  logic [ByteW-1:0]   byte_sel, byte_d;
  logic [ByteW-1:0]   bytes_w [MaxBytes];

  assign out_free    = !oval_q || !out_stall_i;
  assign emit        = busy_q && out_free;
  assign done        = emit && (pos_q == '0);
  assign ser_ready_o = !busy_q || done;
  assign load        = ctl_i.valid && ser_ready_o;

  // bytes above the value width read as zero
  assign padded = PadW'(val_q);
  for (genvar b = 0; b < MaxBytes; b++) begin : g_bytes
    assign bytes_w[b] = padded[b*ByteW +: ByteW];
  end

  assign byte_sel = bytes_w[pos_q];
  assign byte_d   = first_q ? {len_q, byte_sel[LowBits-1:0]} : byte_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      if (load) busy_q <= 1'b1;
      else if (done) busy_q <= 1'b0;
      if (emit) oval_q <= 1'b1;
      else if (!out_stall_i) oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      val_q   <= value_i;
      fin_q   <= ctl_i.final_value;
      len_q   <= ctl_i.len_m1;
      pos_q   <= PosW'(ctl_i.len_m1);
      first_q <= 1'b1;
    end else if (emit) begin
      pos_q   <= pos_q - PosW'(1);
      first_q <= 1'b0;
    end
    if (emit) begin
      obyte_q <= byte_d;
      olast_q <= (pos_q == '0);
      oeob_q  <= (pos_q == '0) && fin_q;
    end
  end

  assign code_byte_o     = obyte_q;
  assign last_of_value_o = olast_q;
  assign end_of_block_o  = oeob_q;
  assign out_valid_o     = oval_q;

endmodule

### rtl/core/length_prefixed_varint_encoder.sv
// channel  direction  handshake                    payload
// input    in         in_valid_i / in_stall_o      value_i, final_value_i
// output   out        out_valid_o / out_stall_i    code_byte_o, last_of_value_o, end_of_block_o
//
// a value of n code bytes (1 to 5 for 32 used bits) is split into its bytes at the byte serializer,
// which drives one byte per cycle into the output register while the output is not stalled
// the first byte of an accepted item passes two length stages, the serializer and the output register
// the length stages take a new item every cycle while the serializer has room
// rst_ni clears all valid bits at once; payload registers keep their contents
// a stall on the output holds the byte in place and backs up through the stages without loss
module length_prefixed_varint_encoder #(
  parameter int unsigned VALUE_BITS = lpve_pkg::ValueBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lpve_pkg::ValueW-1:0] value_i,
  input  logic                        final_value_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  output logic [lpve_pkg::ByteW-1:0]  code_byte_o,
  output logic                        last_of_value_o,
  output logic                        end_of_block_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i
);
  import lpve_pkg::*;

  // only the bits the port carries can be set
  localparam int unsigned VW = (VALUE_BITS < ValueW) ? VALUE_BITS : ValueW;

  ctl_t          ctl;
  logic [VW-1:0] value_s2;
  logic          ser_ready;

  lpve_front #(.VW(VW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .final_value_i(final_value_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .ctl_o        (ctl),
    .value_o      (value_s2),
    .ser_ready_i  (ser_ready)
  );

  lpve_ser #(.VW(VW)) u_ser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .value_i        (value_s2),
    .ser_ready_o    (ser_ready),
    .code_byte_o    (code_byte_o),
    .last_of_value_o(last_of_value_o),
    .end_of_block_o (end_of_block_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i)
  );

endmodule

### rtl/core/lpve_checker.sv
`include "length_prefixed_varint_encoder_macros.svh"

module lpve_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lpve_pkg::ByteW-1:0]  code_byte_o,
  input logic                        last_of_value_o,
  input logic                        end_of_block_o
);
  import lpve_pkg::*;

  logic               out_acc;
  logic               first_q;
  logic [LenBits-1:0] rem_q;

  assign out_acc = out_valid_o && !out_stall_i;

  // follow the length field of each code across its bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      rem_q   <= '0;
    end else if (out_acc) begin
      first_q <= last_of_value_o;
      rem_q   <= first_q ? code_byte_o[ByteW-1 -: LenBits] : rem_q - LenBits'(1);
    end
  end

  `LPVE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(code_byte_o) && $stable(last_of_value_o) && $stable(end_of_block_o), "output byte changed while stalled")
  `LPVE_ASSERT_NOW(a_eob_last, out_valid_o && end_of_block_o, last_of_value_o, "end of block off the last byte of a code")
  `LPVE_ASSERT_NOW(a_first_len, out_acc && first_q, last_of_value_o == (code_byte_o[ByteW-1 -: LenBits] == '0), "single-byte code marking wrong")
  `LPVE_ASSERT_NOW(a_tail_len, out_acc && !first_q, last_of_value_o == (rem_q == LenBits'(1)), "code length disagrees with its prefix")

endmodule

bind length_prefixed_varint_encoder lpve_checker u_lpve_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .code_byte_o    (code_byte_o),
  .last_of_value_o(last_of_value_o),
  .end_of_block_o (end_of_block_o)
);
